[src/assert_macros.svh]
// Assertion helpers shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define RIST_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rist assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RIST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rist assertion failed");

`else

`define RIST_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define RIST_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

[src/rist_pkg.sv]
`default_nettype none

package rist_pkg;

    localparam int unsigned ACTION_W = 2;
    localparam int unsigned INODE_W  = 16;
    localparam int unsigned SLOT_W   = 5;
    localparam int unsigned REF_W    = 8;
    localparam int unsigned STATUS_W = 3;

    // Request action codes.
    localparam logic [ACTION_W-1:0] ACT_GET   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CLAIMED     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL        = 3'd2;
    localparam logic [STATUS_W-1:0] ST_PUT_DONE    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PUT_IGNORED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd5;
    localparam logic [STATUS_W-1:0] ST_SATURATED   = 3'd6;

    localparam logic [REF_W-1:0] REF_MAX = 8'hFF;
    localparam logic [REF_W-1:0] REF_ONE = 8'h01;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INODE_W-1:0]  inode_number;
        logic [SLOT_W-1:0]   slot_index;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [REF_W-1:0]    ref_total;
        logic                write_back;
        logic [INODE_W-1:0]  slot_inode;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan;
        logic get_upd;
        logic put_rd;
        logic put_upd;
        logic clear;
        logic emit;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic found;
        logic scan_end;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

[src/rist_if.sv]
`default_nettype none

interface rist_req_if;
    logic              valid;
    logic              ready;
    rist_pkg::t_req    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rist_rsp_if;
    logic              valid;
    logic              ready;
    rist_pkg::t_rsp    payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/rist_ctrl.sv]
`default_nettype none

module rist_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic [rist_pkg::ACTION_W-1:0]   i_action,
    input  rist_pkg::t_sts                  i_sts,
    output logic                            o_req_ready,
    output rist_pkg::t_cmd                  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_GET_UPD,
        S_PUT_RD,
        S_PUT_UPD,
        S_CLEAR,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.accept = i_req_valid;
                if (i_req_valid) begin
                    unique case (i_action)
                        rist_pkg::ACT_GET:   n_state = S_SCAN;
                        rist_pkg::ACT_PUT:   n_state = S_PUT_RD;
                        rist_pkg::ACT_CLEAR: n_state = S_CLEAR;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.found || i_sts.scan_end) begin
                    n_state = S_GET_UPD;
                end
            end
            S_GET_UPD: begin
                o_cmd.get_upd = 1'b1;
                n_state       = S_EMIT;
            end
            S_PUT_RD: begin
                o_cmd.put_rd = 1'b1;
                n_state      = S_PUT_UPD;
            end
            S_PUT_UPD: begin
                o_cmd.put_upd = 1'b1;
                n_state       = S_EMIT;
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = i_sts.out_free;
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[src/rist_datapath.sv]
`default_nettype none
`include "assert_macros.svh"

module rist_datapath #(
    parameter int unsigned SLOTS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rist_pkg::t_cmd  i_cmd,
    output rist_pkg::t_sts  o_sts,
    input  rist_pkg::t_req  i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output rist_pkg::t_rsp  o_rsp
);

    localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned CW = $clog2(SLOTS + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
    localparam logic [CW-1:0] SLOTS_C  = CW'(SLOTS);

    // Slot storage: one read port and one write port per memory.
    logic [rist_pkg::INODE_W-1:0] r_mem_inode [SLOTS];
    logic [rist_pkg::REF_W-1:0]   r_mem_refs  [SLOTS];
    logic [rist_pkg::INODE_W-1:0] r_rd_inode;
    logic [rist_pkg::REF_W-1:0]   r_rd_refs;

    // A slot is live from its claim until a put drops its count to zero, a clear or reset.
    logic [SLOTS-1:0]             r_live;

    rist_pkg::t_req               r_req;
    rist_pkg::t_rsp               r_res;
    rist_pkg::t_rsp               n_res;
    rist_pkg::t_rsp               r_out;
    logic                         r_out_valid;

    // Scan state.
    logic [CW-1:0]                r_scan_addr;
    logic                         r_cmp_valid;
    logic [IW-1:0]                r_cmp_idx;
    logic                         r_found;
    logic [IW-1:0]                r_hit_idx;
    logic [rist_pkg::REF_W-1:0]   r_hit_refs;
    logic                         r_free_found;
    logic [IW-1:0]                r_free_idx;
    logic                         r_scan_end;

    logic                         rd_en;
    logic [IW-1:0]                rd_addr;
    logic [IW-1:0]                put_idx;
    logic                         put_ok;
    logic                         cmp_hit;
    logic                         wr_refs_en;
    logic                         wr_inode_en;
    logic [IW-1:0]                wr_addr;
    logic [rist_pkg::REF_W-1:0]   wr_refs;
    logic                         live_set;
    logic                         live_clr;
    logic [rist_pkg::REF_W-1:0]   dec_refs;

    assign put_idx  = IW'(r_req.slot_index);
    assign put_ok   = (32'(r_req.slot_index) < SLOTS) && r_live[put_idx];
    assign cmp_hit  = r_live[r_cmp_idx] && (r_rd_inode == r_req.inode_number);
    assign dec_refs = r_rd_refs - rist_pkg::REF_W'(1);

    always_comb begin
        rd_addr = i_cmd.put_rd ? put_idx : r_scan_addr[IW-1:0];
        rd_en   = i_cmd.put_rd || (i_cmd.scan && (r_scan_addr < SLOTS_C));
    end

    always_comb begin
        n_res       = r_res;
        wr_refs_en  = 1'b0;
        wr_inode_en = 1'b0;
        wr_addr     = r_hit_idx;
        wr_refs     = '0;
        live_set    = 1'b0;
        live_clr    = 1'b0;
        if (i_cmd.get_upd) begin
            if (r_found) begin
                n_res.slot       = rist_pkg::SLOT_W'(r_hit_idx);
                n_res.write_back = 1'b0;
                n_res.slot_inode = r_req.inode_number;
                if (r_hit_refs == rist_pkg::REF_MAX) begin
                    n_res.status    = rist_pkg::ST_SATURATED;
                    n_res.ref_total = rist_pkg::REF_MAX;
                end else begin
                    wr_refs_en      = 1'b1;
                    wr_refs         = r_hit_refs + rist_pkg::REF_W'(1);
                    n_res.status    = rist_pkg::ST_HIT;
                    n_res.ref_total = wr_refs;
                end
            end else if (r_free_found) begin
                wr_addr          = r_free_idx;
                wr_refs_en       = 1'b1;
                wr_inode_en      = 1'b1;
                wr_refs          = rist_pkg::REF_ONE;
                live_set         = 1'b1;
                n_res.status     = rist_pkg::ST_CLAIMED;
                n_res.slot       = rist_pkg::SLOT_W'(r_free_idx);
                n_res.ref_total  = rist_pkg::REF_ONE;
                n_res.write_back = 1'b0;
                n_res.slot_inode = r_req.inode_number;
            end else begin
                n_res        = '0;
                n_res.status = rist_pkg::ST_FULL;
            end
        end else if (i_cmd.put_upd) begin
            n_res      = '0;
            n_res.slot = r_req.slot_index;
            if (put_ok) begin
                wr_addr          = put_idx;
                wr_refs_en       = 1'b1;
                wr_refs          = dec_refs;
                live_clr         = (dec_refs == '0);
                n_res.status     = rist_pkg::ST_PUT_DONE;
                n_res.ref_total  = dec_refs;
                n_res.write_back = (dec_refs == '0);
                n_res.slot_inode = r_rd_inode;
            end else begin
                n_res.status = rist_pkg::ST_PUT_IGNORED;
            end
        end else if (i_cmd.clear) begin
            n_res        = '0;
            n_res.status = rist_pkg::ST_CLEARED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_inode <= r_mem_inode[rd_addr];
            r_rd_refs  <= r_mem_refs[rd_addr];
        end
        if (wr_refs_en) begin
            r_mem_refs[wr_addr] <= wr_refs;
        end
        if (wr_inode_en) begin
            r_mem_inode[wr_addr] <= r_req.inode_number;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_live <= '0;
        end else begin
            if (live_set) begin
                r_live[wr_addr] <= 1'b1;
            end
            if (live_clr) begin
                r_live[wr_addr] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req <= i_req;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.accept) begin
            r_scan_addr  <= '0;
            r_cmp_valid  <= 1'b0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_scan_end   <= 1'b0;
        end else if (i_cmd.scan) begin
            if (r_scan_addr < SLOTS_C) begin
                r_scan_addr <= r_scan_addr + CW'(1);
                r_cmp_valid <= 1'b1;
                r_cmp_idx   <= r_scan_addr[IW-1:0];
            end else begin
                r_cmp_valid <= 1'b0;
            end
            if (r_cmp_valid && !r_found) begin
                if (cmp_hit) begin
                    r_found    <= 1'b1;
                    r_hit_idx  <= r_cmp_idx;
                    r_hit_refs <= r_rd_refs;
                end
                if (!r_live[r_cmp_idx] && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_cmp_idx;
                end
                if (r_cmp_idx == LAST_IDX) begin
                    r_scan_end <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_sts.found    = r_found;
    assign o_sts.scan_end = r_scan_end;
    assign o_sts.out_free = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid    = r_out_valid;
    assign o_rsp          = r_out;

    `RIST_ASSERT_IMPL(a_no_overwrite, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || i_rsp_ready)
    `RIST_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, i_cmd.clear, r_live == '0)
    `RIST_ASSERT_IMPL(a_hit_live, i_clk, i_rst_n, i_cmd.get_upd && r_found, r_live[r_hit_idx])
    `RIST_ASSERT_IMPL(a_wb_zero, i_clk, i_rst_n, r_out_valid && r_out.write_back,
        (r_out.ref_total == '0) && (r_out.status == rist_pkg::ST_PUT_DONE))

endmodule

`default_nettype wire

[src/refcounted_inode_slot_table.sv]
// Requests are handled one at a time. A get scans the slots in order, one slot per cycle, and
// stops early on a hit; a put reads and updates its slot; a clear drops every live bit. The
// result then waits in the controller until the output register is free or being drained.
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) empties every slot; inode numbers stay unset until claimed.
`default_nettype none

module refcounted_inode_slot_table #(
    parameter int unsigned SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rist_req_if.sink     i_req,
    rist_rsp_if.source   o_rsp
);

    // The controller sequences each request: a get walks the slots in order until
    // a hit or the last slot, looking for a live slot holding the requested inode
    // while remembering the lowest free slot; a put reads its slot once and writes
    // the new count back if the slot is live; a clear drops all live bits at once.
    // The datapath owns the slot memories, the live bits and the result registers.
    rist_pkg::t_cmd cmd;
    rist_pkg::t_sts sts;
    logic           req_ready;
    logic           rsp_valid;
    rist_pkg::t_rsp rsp_payload;

    rist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_action    (i_req.payload.action),
        .i_sts       (sts),
        .o_req_ready (req_ready),
        .o_cmd       (cmd)
    );

    rist_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req       (i_req.payload),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp       (rsp_payload)
    );

    // A request is accepted only while the controller is idle.
    assign i_req.ready   = req_ready;

    // Results leave from a registered output stage.
    assign o_rsp.valid   = rsp_valid;
    assign o_rsp.payload = rsp_payload;

endmodule

`default_nettype wire
